>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
// Define ASSERT_OFF to compile every check out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("%m: assertion failed");

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: implication failed");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/lcpc_pkg.sv
// Constants and register map of the linear to circular polarisation converter.
// No dependencies.
package lcpc_pkg;

    localparam int SAMPLE_W           = 16;
    localparam int NARROW_W           = 8;
    localparam int COEF_W             = 16;
    localparam int COEF_FRAC_BITS_DEF = 14;
    localparam int APB_AW             = 4;
    localparam int APB_DW             = 32;

    localparam logic signed [COEF_W-1:0] ROT_COS_RST = 16'sd0;
    localparam logic signed [COEF_W-1:0] ROT_SIN_RST = 16'sd16384;

    typedef enum logic [1:0] {
        REG_WIDE_SAMPLES = 2'd0,
        REG_ROT_COS      = 2'd1,
        REG_ROT_SIN      = 2'd2,
        REG_NONE         = 2'd3
    } reg_idx_t;

endpackage

>>> hw/rtl/linear_to_circular_pol_convert.sv
// Linear to circular polarisation converter: rotate Y, form X+Y' and X-Y', saturate.
// Depends on lcpc_pkg and assert_macros.svh.
//
//  channel | role        | payload
//  s_      | sample in   | tdata: x_re, x_im, y_re, y_im (16 bits each, offset binary)
//  m_      | result out  | tdata: sum_re, sum_im, diff_re, diff_im; tuser: clipped
//  APB     | config      | wide_samples @0x0, rot_cos @0x4, rot_sin @0x8
//
// One word per cycle sustained while m_tready stays high; a word passes the input, product and
// result registers, with the four 16x16 multipliers and the add/saturate stage between them.
// Synchronous active-low reset empties the pipeline and loads register defaults.
// A stall on m_ holds the result register and backs up stage by stage to s_tready.
`include "assert_macros.svh"

module linear_to_circular_pol_convert #(
    parameter int COEF_FRAC_BITS = lcpc_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // [15:0] x_re, [31:16] x_im, [47:32] y_re, [63:48] y_im
    input  logic [4*lcpc_pkg::SAMPLE_W-1:0] s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [15:0] sum_re, [31:16] sum_im, [47:32] diff_re, [63:48] diff_im
    output logic [4*lcpc_pkg::SAMPLE_W-1:0] m_tdata,
    // [0] clipped
    output logic                        m_tuser,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lcpc_pkg::APB_AW-1:0] paddr,
    input  logic [lcpc_pkg::APB_DW-1:0] pwdata,
    output logic [lcpc_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import lcpc_pkg::*;

    localparam int PROD_W  = SAMPLE_W + COEF_W;
    localparam int ROT_W   = PROD_W + 1;
    localparam int XS_W    = SAMPLE_W + COEF_FRAC_BITS;
    localparam int SUM_W   = ((ROT_W > XS_W) ? ROT_W : XS_W) + 1;
    localparam int SHIFT_W = SUM_W - COEF_FRAC_BITS;

    localparam logic signed [SHIFT_W-1:0] WIDE_MAX   = SHIFT_W'(2**(SAMPLE_W-1) - 1);
    localparam logic signed [SHIFT_W-1:0] WIDE_MIN   = -SHIFT_W'(2**(SAMPLE_W-1));
    localparam logic signed [SHIFT_W-1:0] NARROW_MAX = SHIFT_W'(2**(NARROW_W-1) - 1);
    localparam logic signed [SHIFT_W-1:0] NARROW_MIN = -SHIFT_W'(2**(NARROW_W-1));
    localparam logic signed [SUM_W-1:0]   TRUNC_BIAS = SUM_W'(2**COEF_FRAC_BITS - 1);

    typedef struct packed {
        logic [SAMPLE_W-1:0] val;
        logic                clip;
    } enc_t;

    function automatic logic signed [SAMPLE_W-1:0] decode(input logic [SAMPLE_W-1:0] d,
                                                          input logic wide);
        logic signed [SAMPLE_W-1:0] r;
        if (wide) begin
            r = {~d[SAMPLE_W-1], d[SAMPLE_W-2:0]};
        end else begin
            r = {{(SAMPLE_W-NARROW_W+1){~d[NARROW_W-1]}}, d[NARROW_W-2:0]};
        end
        return r;
    endfunction

    function automatic enc_t encode(input logic signed [SUM_W-1:0] s, input logic wide);
        logic signed [SUM_W-1:0]   biased;
        logic signed [SHIFT_W-1:0] v;
        logic signed [SHIFT_W-1:0] hi;
        logic signed [SHIFT_W-1:0] lo;
        enc_t                      e;
        biased = s[SUM_W-1] ? (s + TRUNC_BIAS) : s;
        v      = SHIFT_W'(biased >>> COEF_FRAC_BITS);
        hi     = wide ? WIDE_MAX : NARROW_MAX;
        lo     = wide ? WIDE_MIN : NARROW_MIN;
        e.clip = 1'b0;
        if (v > hi) begin
            v      = hi;
            e.clip = 1'b1;
        end
        if (v < lo) begin
            v      = lo;
            e.clip = 1'b1;
        end
        if (wide) begin
            e.val = {~v[SAMPLE_W-1], v[SAMPLE_W-2:0]};
        end else begin
            e.val = {{(SAMPLE_W-NARROW_W){1'b0}}, ~v[NARROW_W-1], v[NARROW_W-2:0]};
        end
        return e;
    endfunction

    // configuration
    logic                     wide_reg;
    logic signed [COEF_W-1:0] cos_reg;
    logic signed [COEF_W-1:0] sin_reg;
    logic                     cfg_wr;
    reg_idx_t                 cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[APB_AW-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wide_reg <= 1'b1;
            cos_reg  <= ROT_COS_RST;
            sin_reg  <= ROT_SIN_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_WIDE_SAMPLES: wide_reg <= pwdata[0];
                REG_ROT_COS:      cos_reg  <= pwdata[COEF_W-1:0];
                REG_ROT_SIN:      sin_reg  <= pwdata[COEF_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_WIDE_SAMPLES: prdata = {{(APB_DW-1){1'b0}}, wide_reg};
            REG_ROT_COS:      prdata = APB_DW'(cos_reg);
            REG_ROT_SIN:      prdata = APB_DW'(sin_reg);
            default:          prdata = '0;
        endcase
    end

    // pipeline control
    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    assign rdy3     = !v3_reg || m_tready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign m_tvalid = v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    // stage 1: decoded samples
    logic signed [SAMPLE_W-1:0] xr1_reg, xi1_reg, yr1_reg, yi1_reg;

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            xr1_reg <= decode(s_tdata[0*SAMPLE_W +: SAMPLE_W], wide_reg);
            xi1_reg <= decode(s_tdata[1*SAMPLE_W +: SAMPLE_W], wide_reg);
            yr1_reg <= decode(s_tdata[2*SAMPLE_W +: SAMPLE_W], wide_reg);
            yi1_reg <= decode(s_tdata[3*SAMPLE_W +: SAMPLE_W], wide_reg);
        end
    end

    // stage 2: rotated Y
    logic signed [PROD_W-1:0]   p_rc, p_is, p_rs, p_ic;
    logic signed [ROT_W-1:0]    pr_next, pi_next;
    logic signed [ROT_W-1:0]    pr2_reg, pi2_reg;
    logic signed [SAMPLE_W-1:0] xr2_reg, xi2_reg;

    assign p_rc    = yr1_reg * cos_reg;
    assign p_is    = yi1_reg * sin_reg;
    assign p_rs    = yr1_reg * sin_reg;
    assign p_ic    = yi1_reg * cos_reg;
    assign pr_next = ROT_W'(p_rc) - ROT_W'(p_is);
    assign pi_next = ROT_W'(p_rs) + ROT_W'(p_ic);

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            pr2_reg <= pr_next;
            pi2_reg <= pi_next;
            xr2_reg <= xr1_reg;
            xi2_reg <= xi1_reg;
        end
    end

    // stage 3: sum, difference, truncate and saturate
    logic signed [SUM_W-1:0] xrs, xis, prs, pis;
    enc_t                    e_sr, e_si, e_dr, e_di;
    logic [4*SAMPLE_W-1:0]   data_next;
    logic                    clip_next;
    logic [4*SAMPLE_W-1:0]   data_reg;
    logic                    clip_reg;

    assign xrs = SUM_W'(xr2_reg) <<< COEF_FRAC_BITS;
    assign xis = SUM_W'(xi2_reg) <<< COEF_FRAC_BITS;
    assign prs = SUM_W'(pr2_reg);
    assign pis = SUM_W'(pi2_reg);

    assign e_sr      = encode(xrs + prs, wide_reg);
    assign e_si      = encode(xis + pis, wide_reg);
    assign e_dr      = encode(xrs - prs, wide_reg);
    assign e_di      = encode(xis - pis, wide_reg);
    assign data_next = {e_di.val, e_dr.val, e_si.val, e_sr.val};
    assign clip_next = e_sr.clip | e_si.clip | e_dr.clip | e_di.clip;

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            data_reg <= data_next;
            clip_reg <= clip_next;
        end
    end

    assign m_tdata = data_reg;
    assign m_tuser = clip_reg;

    logic narrow_hi_zero;
    logic wide_at_limit;

    assign narrow_hi_zero = m_tdata[15:8] == 8'h00 && m_tdata[31:24] == 8'h00 &&
                            m_tdata[47:40] == 8'h00 && m_tdata[63:56] == 8'h00;
    assign wide_at_limit  = m_tdata[15:0] == 16'h0000 || m_tdata[15:0] == 16'hFFFF ||
                            m_tdata[31:16] == 16'h0000 || m_tdata[31:16] == 16'hFFFF ||
                            m_tdata[47:32] == 16'h0000 || m_tdata[47:32] == 16'hFFFF ||
                            m_tdata[63:48] == 16'h0000 || m_tdata[63:48] == 16'hFFFF;

    `ASSERT_IMPLIES(a_accept_fills, aclk, aresetn, s_tvalid && s_tready, ##1 v1_reg)
    `ASSERT_IMPLIES(a_narrow_high_zero, aclk, aresetn, m_tvalid && !wide_reg, narrow_hi_zero)
    `ASSERT_IMPLIES(a_clip_at_limit, aclk, aresetn, m_tvalid && m_tuser && wide_reg, wide_at_limit)
    `ASSERT_PROP(a_bubble_ready, aclk, aresetn, !v1_reg |-> s_tready)

endmodule

>>> sim/testbench.sv
// Self-checking bench for linear_to_circular_pol_convert: drives sample words under
// several coefficient and width settings and predicts every result word in place.
// Depends on lcpc_pkg and the converter RTL.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lcpc_pkg::*;

    localparam int FRAC        = COEF_FRAC_BITS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 64;
    localparam int PHASE_WORDS = 90;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic        clipped;
        logic [15:0] diff_im;
        logic [15:0] diff_re;
        logic [15:0] sum_im;
        logic [15:0] sum_re;
    } circ_word_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [4*SAMPLE_W-1:0] s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [4*SAMPLE_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_AW-1:0]     paddr    = '0;
    logic [APB_DW-1:0]     pwdata   = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    logic               cfg_wide = 1'b1;
    logic signed [15:0] cfg_cos  = ROT_COS_RST;
    logic signed [15:0] cfg_sin  = ROT_SIN_RST;

    logic [63:0] sample_q[$];
    circ_word_t  circ_q[$];

    int src_gap_pct = 25;
    int snk_gap_pct = 25;
    int src_gap     = 0;
    int snk_gap     = 0;
    int hold_ticket = 0;
    int hold_served = 0;
    int hold_left   = 0;
    int mismatches  = 0;
    int results     = 0;
    int cycles      = 0;
    bit word_taken  = 1'b0;

    string field_name[5] = '{"sum_re", "sum_im", "diff_re", "diff_im", "clipped"};

    linear_to_circular_pol_convert #(
        .COEF_FRAC_BITS(FRAC)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),   // [15:0] x_re, [31:16] x_im, [47:32] y_re, [63:48] y_im
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),   // [15:0] sum_re, [31:16] sum_im, [47:32] diff_re, [63:48] diff_im
        .m_tuser (m_tuser),   // [0] clipped
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic longint sample_value(logic [15:0] raw);
        logic signed [15:0] wide_v;
        logic signed [7:0]  narrow_v;
        wide_v   = raw ^ 16'h8000;
        narrow_v = raw[7:0] ^ 8'h80;
        if (cfg_wide)
            return longint'(wide_v);
        return longint'(narrow_v);
    endfunction

    function automatic logic [15:0] saturate_sample(longint scaled, inout bit clip);
        longint v;
        longint lo;
        longint hi;
        v  = (scaled >= 0) ? (scaled >>> FRAC) : -((-scaled) >>> FRAC);
        lo = cfg_wide ? -32768 : -128;
        hi = cfg_wide ? 32767 : 127;
        if (v > hi) begin
            v    = hi;
            clip = 1'b1;
        end
        if (v < lo) begin
            v    = lo;
            clip = 1'b1;
        end
        if (cfg_wide)
            return v[15:0] ^ 16'h8000;
        return {8'h00, v[7:0] ^ 8'h80};
    endfunction

    function automatic circ_word_t circ_from_linear(logic [63:0] w);
        longint     xr, xi, yr, yi, rot_re, rot_im;
        bit         clip;
        circ_word_t r;
        xr      = sample_value(w[15:0]);
        xi      = sample_value(w[31:16]);
        yr      = sample_value(w[47:32]);
        yi      = sample_value(w[63:48]);
        rot_re  = yr * longint'(cfg_cos) - yi * longint'(cfg_sin);
        rot_im  = yr * longint'(cfg_sin) + yi * longint'(cfg_cos);
        clip    = 1'b0;
        r.sum_re  = saturate_sample((xr <<< FRAC) + rot_re, clip);
        r.sum_im  = saturate_sample((xi <<< FRAC) + rot_im, clip);
        r.diff_re = saturate_sample((xr <<< FRAC) - rot_re, clip);
        r.diff_im = saturate_sample((xi <<< FRAC) - rot_im, clip);
        r.clipped = clip;
        return r;
    endfunction

    function automatic logic [63:0] pack_xy(logic [15:0] xr, logic [15:0] xi,
                                            logic [15:0] yr, logic [15:0] yi);
        return {yi, yr, xi, xr};
    endfunction

    function automatic logic [15:0] random_field();
        logic [7:0] rim[4];
        rim = '{8'h00, 8'hFF, 8'h7F, 8'h80};
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            3:       return {8'($urandom), rim[$urandom_range(0, 3)]};
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] random_coef();
        case ($urandom_range(0, 7))
            0:       return 16'sd16384;
            1:       return -16'sd16384;
            2:       return 16'($urandom);
            3:       return 16'h0000;
            default: return 16'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    function automatic logic [15:0] field_of(circ_word_t w, int f);
        if (f == 4)
            return {15'b0, w.clipped};
        return w[16*f +: 16];
    endfunction

    task automatic note_mismatch(string what);
        if (mismatches < MAX_REPORTS)
            $display("[%0t] result %0d: %s", $realtime, results, what);
        mismatches++;
    endtask

    task automatic write_reg(reg_idx_t idx, logic [15:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{16{value[15]}}, value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_WIDE_SAMPLES: cfg_wide = value[0];
            REG_ROT_COS:      cfg_cos  = value;
            REG_ROT_SIN:      cfg_sin  = value;
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain_results();
        while (sample_q.size() != 0 || s_tvalid || circ_q.size() != 0)
            @(posedge aclk);
    endtask

    // sample word driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !word_taken) begin
            // hold the offered word
        end else begin
            if (src_gap == 0 && src_gap_pct > 0 && $urandom_range(0, 99) < src_gap_pct)
                src_gap = $urandom_range(1, 4);
            if (src_gap > 0) begin
                src_gap--;
                s_tvalid <= 1'b0;
            end else if (sample_q.size() > 0) begin
                s_tdata  <= sample_q.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        word_taken = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            circ_q.push_back(circ_from_linear(s_tdata));
            word_taken = 1'b1;
        end
    end

    // result back-pressure
    always @(negedge aclk) begin
        if (hold_ticket != hold_served) begin
            hold_served = hold_ticket;
            hold_left   = LONG_HOLD;
        end
        if (hold_left == 0 && snk_gap == 0 && snk_gap_pct > 0 &&
            $urandom_range(0, 99) < snk_gap_pct)
            snk_gap = $urandom_range(1, 4);
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (snk_gap > 0) begin
            snk_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        circ_word_t got;
        circ_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata};
            if (circ_q.size() == 0) begin
                note_mismatch($sformatf("unexpected word %h", got));
            end else begin
                want = circ_q.pop_front();
                for (int f = 0; f < 5; f++) begin
                    if (field_of(got, f) !== field_of(want, f))
                        note_mismatch($sformatf("%s expected %h got %h", field_name[f],
                                                field_of(want, f), field_of(got, f)));
                end
            end
            results++;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int p;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // reset coefficient: plain +90 degree rotation, 16-bit samples
        sample_q.push_back(pack_xy(16'h8000, 16'h8000, 16'h8000, 16'h8000));
        sample_q.push_back(pack_xy(16'h0000, 16'h0000, 16'h0000, 16'h0000));
        sample_q.push_back(pack_xy(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        sample_q.push_back(pack_xy(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF));
        sample_q.push_back(pack_xy(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000));
        sample_q.push_back(pack_xy(16'h8001, 16'h7FFF, 16'h8001, 16'h7FFF));
        sample_q.push_back(pack_xy(16'hC000, 16'h4000, 16'hC000, 16'h4000));
        drain_results();

        // 8-bit samples, junk in the upper bytes, unmapped register write
        write_reg(REG_WIDE_SAMPLES, 16'd0);
        write_reg(REG_ROT_COS, -16'sd16384);
        write_reg(REG_ROT_SIN, 16'sd0);
        write_reg(REG_NONE, 16'hBEEF);
        sample_q.push_back(pack_xy(16'h0080, 16'h0080, 16'h0080, 16'h0080));
        sample_q.push_back(pack_xy(16'h0000, 16'h0000, 16'h0000, 16'h0000));
        sample_q.push_back(pack_xy(16'h00FF, 16'h00FF, 16'h0000, 16'h0000));
        sample_q.push_back(pack_xy(16'hFFFF, 16'hFF00, 16'hAA55, 16'h55AA));
        sample_q.push_back(pack_xy(16'hFF80, 16'h0080, 16'h7F80, 16'h8080));
        drain_results();

        // coefficient patterns beyond the nominal range
        write_reg(REG_WIDE_SAMPLES, 16'd1);
        write_reg(REG_ROT_COS, 16'h7FFF);
        write_reg(REG_ROT_SIN, 16'h8000);
        sample_q.push_back(pack_xy(16'h8000, 16'h8000, 16'h8000, 16'h8000));
        sample_q.push_back(pack_xy(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        sample_q.push_back(pack_xy(16'h0000, 16'h0000, 16'h0000, 16'h0000));
        sample_q.push_back(pack_xy(16'h8000, 16'h8000, 16'h8001, 16'h7FFF));
        sample_q.push_back(pack_xy(16'h7FFF, 16'h8001, 16'h8003, 16'h7FFD));
        drain_results();

        // 45 degree coefficient: truncation toward zero on both signs
        write_reg(REG_WIDE_SAMPLES, 16'd0);
        write_reg(REG_ROT_COS, 16'sd11585);
        write_reg(REG_ROT_SIN, -16'sd11585);
        sample_q.push_back(pack_xy(16'h0080, 16'h0080, 16'h0081, 16'h007F));
        sample_q.push_back(pack_xy(16'h0085, 16'h007B, 16'h0083, 16'h0087));
        sample_q.push_back(pack_xy(16'h00FF, 16'h0000, 16'h00FF, 16'h0000));
        sample_q.push_back(pack_xy(16'h1201, 16'h34FE, 16'h5679, 16'h7887));
        drain_results();

        for (p = 0; p < 6; p++) begin
            src_gap_pct = (p == 2 || p == 5) ? 0 : 30;
            snk_gap_pct = (p == 2 || p == 5) ? 0 : 30;
            write_reg(REG_WIDE_SAMPLES, (p % 2 == 1) ? 16'd1 : 16'd0);
            write_reg(REG_ROT_COS, (p == 0) ? 16'sd16384 : random_coef());
            write_reg(REG_ROT_SIN, (p == 0) ? 16'sd16384 : random_coef());
            repeat (PHASE_WORDS)
                sample_q.push_back(pack_xy(random_field(), random_field(),
                                           random_field(), random_field()));
            if (p == 1)
                hold_ticket++;
            drain_results();
        end

        repeat (8) @(posedge aclk);
        mismatches += circ_q.size();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
